// ===== design/sliding_window_variance_std_assert.svh =====
// Assertion macros used by the checker file swvs_chk.
// No dependencies.
`ifndef SLIDING_WINDOW_VARIANCE_STD_ASSERT_SVH
`define SLIDING_WINDOW_VARIANCE_STD_ASSERT_SVH

// same-cycle implication
`define SWVS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SWVS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/swvs_pkg.sv =====
// Shared types and constants for the sliding window variance block.
// No dependencies.
`default_nettype none
package swvs_pkg;
   localparam int SAMPLE_W = 16;
   localparam int WIN_MAX  = 64;
   localparam int RING_AW  = 6;
   localparam int LEN_W    = 7;
   localparam int SUM_W    = 23;
   localparam int SQS_W    = 37;
   localparam int NUM_W    = 43;
   localparam int DEN_W    = 12;
   localparam int RES_W    = 32;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 7;

   localparam logic [CSR_AW-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_RESULT_MODE   = 2'd1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       sample_present;
   } req_type;

   typedef struct packed {
      logic             result_present;
      logic [RES_W-1:0] result;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic sqrt_en;
   } dsq_cmd_type;
endpackage
`default_nettype wire

// ===== design/sliding_window_variance_std.sv =====
// Sliding window sample variance / standard deviation over a 64-entry sample ring.
// A request is accepted only while idle, one at a time. The block reads and accumulates
// the window from the ring through its single read port, forms the products, runs the
// bit-serial division and, in std mode, the square root, then loads the response register,
// waiting while a previous response still waits on rsp_ready. During warm-up, or for a
// window holding a null sample, it returns a null result without dividing.
// Depends on swvs_pkg and swvs_dsq.
`default_nettype none
module sliding_window_variance_std (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire swvs_pkg::req_type           req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output swvs_pkg::rsp_type                rsp_payload,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [swvs_pkg::CSR_AW-1:0] csr_index,
   input  wire logic [swvs_pkg::CSR_DW-1:0] csr_data
);
   import swvs_pkg::*;

   typedef enum logic [2:0] {ST_IDLE, ST_ACC, ST_MUL, ST_SUB, ST_SERIAL, ST_FIN} state_type;

   state_type                 state_ff;
   logic [RING_AW-1:0]        wr_idx_ff;
   logic [LEN_W-1:0]          seen_ff;
   logic [LEN_W-1:0]          wl_ff;
   logic                      mode_ff;
   logic [LEN_W-1:0]          len_ff;
   logic                      run_mode_ff;
   logic [DEN_W-1:0]          den_ff;
   logic [RING_AW-1:0]        base_ff;
   logic [LEN_W-1:0]          k_ff;
   logic                      rd_vld_ff;
   logic [SAMPLE_W:0]         rd_ff;
   logic                      sq_vld_ff;
   logic [2*SAMPLE_W-1:0]     sq_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic [SQS_W-1:0]          sqs_ff;
   logic                      nul_ff;
   logic [NUM_W-1:0]          pa_ff;
   logic [NUM_W-1:0]          pb_ff;
   logic                      res_pres_ff;
   logic [RES_W-1:0]          res_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   logic [SAMPLE_W:0]         ring [WIN_MAX];

   logic                      accept;
   logic [LEN_W-1:0]          len_in;
   logic [LEN_W-1:0]          seen_in;
   logic                      issue;
   logic [RING_AW-1:0]        rd_addr;
   logic signed [SAMPLE_W-1:0] sx;
   logic signed [2*SAMPLE_W-1:0] sx_w;
   logic [SUM_W-1:0]          smag;
   logic                      rsp_load;
   dsq_cmd_type               dsq_cmd;
   logic                      dsq_done;
   logic [RES_W-1:0]          dsq_res;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      if (wl_ff < LEN_W'(2)) begin
         len_in = LEN_W'(2);
      end else if (wl_ff > LEN_W'(WIN_MAX)) begin
         len_in = LEN_W'(WIN_MAX);
      end else begin
         len_in = wl_ff;
      end
      seen_in = (seen_ff == LEN_W'(WIN_MAX)) ? seen_ff : seen_ff + LEN_W'(1);
      issue   = (state_ff == ST_ACC) && (k_ff < len_ff);
      rd_addr = base_ff - k_ff[RING_AW-1:0];
      sx      = rd_ff[SAMPLE_W-1:0];
      sx_w    = (2*SAMPLE_W)'(sx);
      smag    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      rsp_load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
      dsq_cmd.start   = (state_ff == ST_SUB);
      dsq_cmd.sqrt_en = run_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ring[wr_idx_ff] <= req_payload.sample_present ?
                            {1'b1, req_payload.sample} : '0;
      end
      rd_ff <= ring[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_idx_ff    <= '0;
         seen_ff      <= '0;
         wl_ff        <= LEN_W'(2);
         mode_ff      <= 1'b0;
         rd_vld_ff    <= 1'b0;
         sq_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_LENGTH: wl_ff   <= csr_data;
               CSR_RESULT_MODE:   mode_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_vld_ff <= issue;
         sq_vld_ff <= rd_vld_ff;
         if (rd_vld_ff) begin
            sum_ff <= sum_ff + SUM_W'(sx);
            sq_ff  <= $unsigned(sx_w * sx_w);
            nul_ff <= nul_ff | ~rd_ff[SAMPLE_W];
         end
         if (sq_vld_ff) begin
            sqs_ff <= sqs_ff + SQS_W'(sq_ff);
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  wr_idx_ff   <= wr_idx_ff + RING_AW'(1);
                  seen_ff     <= seen_in;
                  len_ff      <= len_in;
                  run_mode_ff <= mode_ff;
                  den_ff      <= DEN_W'(len_in) * (DEN_W'(len_in) - DEN_W'(1));
                  base_ff     <= wr_idx_ff;
                  k_ff        <= '0;
                  sum_ff      <= '0;
                  sqs_ff      <= '0;
                  nul_ff      <= 1'b0;
                  res_pres_ff <= 1'b0;
                  res_ff      <= '0;
                  state_ff    <= (seen_in < len_in) ? ST_FIN : ST_ACC;
               end
            end
            ST_ACC: begin
               if (issue) begin
                  k_ff <= k_ff + LEN_W'(1);
               end else if (!rd_vld_ff && !sq_vld_ff) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               pa_ff    <= NUM_W'(sqs_ff) * NUM_W'(len_ff);
               pb_ff    <= NUM_W'(smag) * NUM_W'(smag);
               state_ff <= nul_ff ? ST_FIN : ST_SUB;
            end
            ST_SUB: begin
               state_ff <= ST_SERIAL;
            end
            ST_SERIAL: begin
               if (dsq_done) begin
                  res_pres_ff <= 1'b1;
                  res_ff      <= dsq_res;
                  state_ff    <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (rsp_load) begin
                  rsp_ff.result_present <= res_pres_ff;
                  rsp_ff.result         <= res_ff;
                  state_ff              <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   swvs_dsq u_dsq (
      .clock  (clock),
      .reset  (reset),
      .cmd    (dsq_cmd),
      .num    (pa_ff - pb_ff),
      .den    (den_ff),
      .done   (dsq_done),
      .result (dsq_res)
   );
endmodule
`default_nettype wire

// ===== design/swvs_dsq.sv =====
// Bit-serial unit: restoring divide, saturation to 32 bits, optional square root.
// Depends on swvs_pkg.
`default_nettype none
module swvs_dsq (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire swvs_pkg::dsq_cmd_type      cmd,
   input  wire logic [swvs_pkg::NUM_W-1:0] num,
   input  wire logic [swvs_pkg::DEN_W-1:0] den,
   output logic                            done,
   output logic [swvs_pkg::RES_W-1:0]      result
);
   import swvs_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT, S_DONE} state_type;

   state_type          state_ff;
   logic [NUM_W-1:0]   q_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [DEN_W:0]     rem_ff;
   logic [5:0]         cnt_ff;
   logic               sqrt_ff;
   logic [RES_W-1:0]   x_ff;
   logic [17:0]        srem_ff;
   logic [15:0]        root_ff;
   logic [RES_W-1:0]   res_ff;

   logic [DEN_W:0]     rem_in;
   logic               qbit;
   logic [RES_W-1:0]   sat;
   logic [17:0]        srem_in;
   logic [17:0]        trial;
   logic               sbit;

   always_comb begin
      rem_in  = {rem_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      qbit    = (rem_in >= {1'b0, den_ff});
      sat     = (|q_ff[NUM_W-1:RES_W]) ? '1 : q_ff[RES_W-1:0];
      srem_in = {srem_ff[15:0], x_ff[RES_W-1:RES_W-2]};
      trial   = {root_ff, 2'b01};
      sbit    = (srem_in >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (cmd.start) begin
                  q_ff     <= num;
                  den_ff   <= den;
                  rem_ff   <= '0;
                  cnt_ff   <= 6'(NUM_W - 1);
                  sqrt_ff  <= cmd.sqrt_en;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= qbit ? rem_in - {1'b0, den_ff} : rem_in;
               q_ff   <= {q_ff[NUM_W-2:0], qbit};
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == '0) begin
                  state_ff <= S_DONE;
               end
            end
            S_SQRT: begin
               srem_ff <= sbit ? srem_in - trial : srem_in;
               root_ff <= {root_ff[14:0], sbit};
               x_ff    <= {x_ff[RES_W-3:0], 2'b00};
               cnt_ff  <= cnt_ff - 6'd1;
               if (cnt_ff == '0) begin
                  res_ff   <= {16'd0, root_ff[14:0], sbit};
                  state_ff <= S_IDLE;
               end
            end
            S_DONE: begin
               if (sqrt_ff) begin
                  x_ff     <= sat;
                  srem_ff  <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= 6'd15;
                  state_ff <= S_SQRT;
               end else begin
                  res_ff   <= sat;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   logic done_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= (state_ff == S_DONE && !sqrt_ff) ||
                    (state_ff == S_SQRT && cnt_ff == '0);
      end
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule
`default_nettype wire

// ===== design/swvs_chk.sv =====
// Port-level checker for the sliding window variance block, bound to the top level.
// Depends on swvs_pkg and sliding_window_variance_std_assert.svh.
`default_nettype none
`include "sliding_window_variance_std_assert.svh"
module swvs_chk (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire swvs_pkg::req_type           req_payload,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire swvs_pkg::rsp_type           rsp_payload,
   input wire logic                        csr_valid,
   input wire logic                        csr_ready,
   input wire logic [swvs_pkg::CSR_AW-1:0] csr_index,
   input wire logic [swvs_pkg::CSR_DW-1:0] csr_data
);
   import swvs_pkg::*;

   `SWVS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SWVS_ASSERT_NOW(a_null_zero, clock, reset, rsp_valid && !rsp_payload.result_present, rsp_payload.result == '0)
   `SWVS_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)
   `SWVS_ASSERT_NEXT(a_csr_open, clock, 1'b0, reset, csr_ready && !rsp_valid)
endmodule

bind sliding_window_variance_std swvs_chk u_chk (.*);
`default_nettype wire
